// ===== sv/aabb_circle_contact_defines.svh =====
// Assertion macros shared by the box/circle contact block.
// Taken in by files that check their own control logic; no other dependencies.
`ifndef AABB_CIRCLE_CONTACT_DEFINES_SVH
`define AABB_CIRCLE_CONTACT_DEFINES_SVH

// Same-cycle implication under the active-low synchronous reset.
`define ACC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the active-low synchronous reset.
`define ACC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/acc_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helper functions for the box/circle contact pipeline.
// No dependencies; every file that uses it refers to it by scoped names.
package acc_pkg;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;
    localparam int LANES      = 4;
    // 0.0001 in Q16.16 rounds up to 7 units.
    localparam logic [30:0] TINY_DIST = 31'd7;

    localparam int LANE_PX = 0;
    localparam int LANE_PY = 1;
    localparam int LANE_NX = 2;
    localparam int LANE_NY = 3;

    typedef struct packed {
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic [30:0]        box_half_width;
        logic [30:0]        box_half_height;
        logic [30:0]        box_scale_x;
        logic [30:0]        box_scale_y;
        logic signed [31:0] circle_center_x;
        logic signed [31:0] circle_center_y;
        logic [30:0]        circle_radius;
        logic [30:0]        circle_scale;
    } in_t;

    // Per-item values that ride along with the arithmetic.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] ccx;
        logic signed [31:0] ccy;
        logic signed [31:0] bpx;
        logic signed [31:0] bpy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        r;
    } carry_t;

    typedef struct packed {
        logic [61:0] n;
        logic [32:0] rem;
        logic [30:0] root;
    } sqrt_t;

    typedef struct packed {
        logic        neg;
        logic [30:0] rem;
        logic [30:0] nlo;
        logic [30:0] q;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [30:0]           den;
    } div_t;

    // (a*b + 0.5) in Q16.16, saturated to 31 bits.
    function automatic logic [30:0] scale_q16(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        logic [61:0] s;
        p = {31'd0, a} * {31'd0, b};
        s = p + 62'h8000;
        return (|s[61:47]) ? 31'h7FFF_FFFF : s[46:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > $signed(36'h0_7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (x < $signed(36'hF_8000_0000)) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== sv/acc_front.sv =====
`timescale 1ns / 1ps
// Front of the contact pipeline: scaling, clamping, squares and the hit test.
// Four register stages. Depends on acc_pkg.
module acc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  acc_pkg::in_t      in_item,
    output logic              out_valid,
    output acc_pkg::carry_t   out_carry,
    output logic [61:0]       out_sum
);

    // Stage 1: scaled sizes and centre offsets.
    logic               s1_valid_reg;
    logic [30:0]        s1_hw_reg, s1_hh_reg, s1_r_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic signed [31:0] s1_ccx_reg, s1_ccy_reg, s1_bcx_reg, s1_bcy_reg;

    // Stage 2: clamped offsets and circle-to-box vector.
    logic signed [33:0] s2_cx_next, s2_cy_next, s2_vx_next, s2_vy_next;
    logic [33:0]        s2_ax_next, s2_ay_next;
    logic               s2_far_next;
    logic               s2_valid_reg, s2_far_reg;
    logic [30:0]        s2_ax_reg, s2_ay_reg;
    acc_pkg::carry_t    s2_carry_next, s2_carry_reg;

    // Stage 3: squares.
    logic               s3_valid_reg, s3_far_reg;
    logic [61:0]        s3_sqx_reg, s3_sqy_reg, s3_rr_reg;
    acc_pkg::carry_t    s3_carry_reg;

    // Stage 4: sum and compare.
    logic [62:0]        s4_sum_next;
    logic               s4_valid_reg;
    logic [61:0]        s4_sum_reg;
    acc_pkg::carry_t    s4_carry_next, s4_carry_reg;

    always_comb begin
        logic signed [33:0] dx, dy, hw, hh;
        dx = {s1_dx_reg[32], s1_dx_reg};
        dy = {s1_dy_reg[32], s1_dy_reg};
        hw = {3'd0, s1_hw_reg};
        hh = {3'd0, s1_hh_reg};
        s2_cx_next = (dx > hw) ? hw : ((dx < -hw) ? -hw : dx);
        s2_cy_next = (dy > hh) ? hh : ((dy < -hh) ? -hh : dy);
        s2_vx_next = s2_cx_next - dx;
        s2_vy_next = s2_cy_next - dy;
        s2_ax_next = s2_vx_next[33] ? 34'(-s2_vx_next) : 34'(s2_vx_next);
        s2_ay_next = s2_vy_next[33] ? 34'(-s2_vy_next) : 34'(s2_vy_next);
        s2_far_next = (s2_ax_next > {3'd0, s1_r_reg}) || (s2_ay_next > {3'd0, s1_r_reg});
        s2_carry_next.hit = 1'b0;
        s2_carry_next.ccx = s1_ccx_reg;
        s2_carry_next.ccy = s1_ccy_reg;
        s2_carry_next.bpx = acc_pkg::sat32(36'(s1_bcx_reg) + 36'(s2_cx_next));
        s2_carry_next.bpy = acc_pkg::sat32(36'(s1_bcy_reg) + 36'(s2_cy_next));
        s2_carry_next.vx  = s2_vx_next[31:0];
        s2_carry_next.vy  = s2_vy_next[31:0];
        s2_carry_next.r   = s1_r_reg;
    end

    always_comb begin
        s4_sum_next = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
        s4_carry_next = s3_carry_reg;
        // Touching counts as a hit; a far vector never forms a valid square.
        s4_carry_next.hit = !s3_far_reg && (s4_sum_next <= {1'b0, s3_rr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_hw_reg  <= acc_pkg::scale_q16(in_item.box_half_width, in_item.box_scale_x);
            s1_hh_reg  <= acc_pkg::scale_q16(in_item.box_half_height, in_item.box_scale_y);
            s1_r_reg   <= acc_pkg::scale_q16(in_item.circle_radius, in_item.circle_scale);
            s1_dx_reg  <= 33'(in_item.circle_center_x) - 33'(in_item.box_center_x);
            s1_dy_reg  <= 33'(in_item.circle_center_y) - 33'(in_item.box_center_y);
            s1_ccx_reg <= in_item.circle_center_x;
            s1_ccy_reg <= in_item.circle_center_y;
            s1_bcx_reg <= in_item.box_center_x;
            s1_bcy_reg <= in_item.box_center_y;

            s2_ax_reg    <= s2_ax_next[30:0];
            s2_ay_reg    <= s2_ay_next[30:0];
            s2_far_reg   <= s2_far_next;
            s2_carry_reg <= s2_carry_next;

            s3_sqx_reg   <= {31'd0, s2_ax_reg} * {31'd0, s2_ax_reg};
            s3_sqy_reg   <= {31'd0, s2_ay_reg} * {31'd0, s2_ay_reg};
            s3_rr_reg    <= {31'd0, s2_carry_reg.r} * {31'd0, s2_carry_reg.r};
            s3_far_reg   <= s2_far_reg;
            s3_carry_reg <= s2_carry_reg;

            s4_sum_reg   <= s4_sum_next[61:0];
            s4_carry_reg <= s4_carry_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_carry = s4_carry_reg;
    assign out_sum   = s4_sum_reg;

endmodule

// ===== sv/acc_sqrt_step.sv =====
`timescale 1ns / 1ps
// One digit stage of the pipelined integer square root (one result bit per stage).
// Depends on acc_pkg.
module acc_sqrt_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  acc_pkg::sqrt_t    in_sq,
    input  acc_pkg::carry_t   in_carry,
    output logic              out_valid,
    output acc_pkg::sqrt_t    out_sq,
    output acc_pkg::carry_t   out_carry
);

    logic [34:0]     trial;
    logic [34:0]     test;
    logic            ge;
    acc_pkg::sqrt_t  sq_next;
    logic            valid_reg;
    acc_pkg::sqrt_t  sq_reg;
    acc_pkg::carry_t carry_reg;

    always_comb begin
        trial = {in_sq.rem, in_sq.n[61:60]};
        test  = {2'b00, in_sq.root, 2'b01};
        ge    = (trial >= test);
        sq_next.rem  = ge ? 33'(trial - test) : trial[32:0];
        sq_next.root = {in_sq.root[29:0], ge};
        sq_next.n    = {in_sq.n[59:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= sq_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_carry = carry_reg;

endmodule

// ===== sv/acc_div_prep.sv =====
`timescale 1ns / 1ps
// Builds the four rounded dividends (circle point and normal, per axis).
// Two register stages: products, then the half-divisor rounding add. Depends on acc_pkg.
module acc_div_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  acc_pkg::carry_t   in_carry,
    input  logic [30:0]       in_dist,
    output logic              out_valid,
    output acc_pkg::div_t     out_div,
    output acc_pkg::carry_t   out_carry
);

    logic [31:0]     ax, ay;
    logic            p1_valid_reg;
    logic [61:0]     p1_prod_reg [acc_pkg::LANES];
    logic            p1_negx_reg, p1_negy_reg;
    logic [30:0]     p1_dist_reg;
    acc_pkg::carry_t p1_carry_reg;
    logic            p2_valid_reg;
    acc_pkg::div_t   p2_div_next, p2_div_reg;
    acc_pkg::carry_t p2_carry_reg;

    // On a hit both magnitudes are at most the radius, so 31 bits hold them.
    assign ax = in_carry.vx[31] ? 32'(-in_carry.vx) : 32'(in_carry.vx);
    assign ay = in_carry.vy[31] ? 32'(-in_carry.vy) : 32'(in_carry.vy);

    always_comb begin
        logic [62:0] num;
        for (int i = 0; i < acc_pkg::LANES; i++) begin
            num = {1'b0, p1_prod_reg[i]} + {33'd0, p1_dist_reg[30:1]};
            p2_div_next.lane[i].rem = num[61:31];
            p2_div_next.lane[i].nlo = num[30:0];
            p2_div_next.lane[i].q   = '0;
            p2_div_next.lane[i].neg = (i == acc_pkg::LANE_PX || i == acc_pkg::LANE_NX)
                                      ? p1_negx_reg : p1_negy_reg;
        end
        p2_div_next.den = p1_dist_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_prod_reg[acc_pkg::LANE_PX] <= {31'd0, ax[30:0]} * {31'd0, in_carry.r};
            p1_prod_reg[acc_pkg::LANE_PY] <= {31'd0, ay[30:0]} * {31'd0, in_carry.r};
            p1_prod_reg[acc_pkg::LANE_NX] <= {15'd0, ax[30:0], 16'd0};
            p1_prod_reg[acc_pkg::LANE_NY] <= {15'd0, ay[30:0], 16'd0};
            p1_negx_reg  <= in_carry.vx[31];
            p1_negy_reg  <= in_carry.vy[31];
            p1_dist_reg  <= in_dist;
            p1_carry_reg <= in_carry;
            p2_div_reg   <= p2_div_next;
            p2_carry_reg <= p1_carry_reg;
        end
    end

    assign out_valid = p2_valid_reg;
    assign out_div   = p2_div_reg;
    assign out_carry = p2_carry_reg;

endmodule

// ===== sv/acc_div_step.sv =====
`timescale 1ns / 1ps
// One quotient-bit stage of the four-lane pipelined restoring divider.
// Depends on acc_pkg.
module acc_div_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  acc_pkg::div_t     in_div,
    input  acc_pkg::carry_t   in_carry,
    output logic              out_valid,
    output acc_pkg::div_t     out_div,
    output acc_pkg::carry_t   out_carry
);

    acc_pkg::div_t   div_next;
    logic            valid_reg;
    acc_pkg::div_t   div_reg;
    acc_pkg::carry_t carry_reg;

    always_comb begin
        logic [31:0] t;
        logic        ge;
        div_next = in_div;
        for (int i = 0; i < acc_pkg::LANES; i++) begin
            t  = {in_div.lane[i].rem, in_div.lane[i].nlo[30]};
            ge = (t >= {1'b0, in_div.den});
            div_next.lane[i].rem = ge ? 31'(t - {1'b0, in_div.den}) : t[30:0];
            div_next.lane[i].nlo = {in_div.lane[i].nlo[29:0], 1'b0};
            div_next.lane[i].q   = {in_div.lane[i].q[29:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg   <= div_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_carry = carry_reg;

endmodule

// ===== sv/aabb_circle_contact.sv =====
`timescale 1ns / 1ps
// Top level of the box/circle contact pipeline, with output register and skid stage.
// Depends on acc_pkg, acc_front, acc_sqrt_step, acc_div_prep, acc_div_step and the defines.
//
//   channel   direction   payload
//   s_axis    in          tdata: box and circle geometry, ten fields
//   m_axis    out         tdata: points, normal, depth; tuser: hit
//
// One item enters per cycle while the skid stage is empty. Each item passes the front, the
// one-bit-per-stage square root and divider chains with the divider prep between them, then the output register.
// Reset clears all valid bits; no clearing pass is needed.
// When the output is stalled the skid stage takes one more result, then the
// whole pipeline holds in place until the skid stage drains.
`include "aabb_circle_contact_defines.svh"

module aabb_circle_contact (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // box_center_x, box_center_y, box_half_width, box_half_height, box_scale_x,
    // box_scale_y, circle_center_x, circle_center_y, circle_radius, circle_scale
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // circle_point_x, circle_point_y, box_point_x, box_point_y, normal_x, normal_y, depth
    output logic [199:0] m_axis_tdata,
    // hit
    output logic [0:0]   m_axis_tuser
);

    localparam int SN = acc_pkg::SQRT_STEPS;
    localparam int DN = acc_pkg::DIV_STEPS;

    logic            en;
    acc_pkg::in_t    in_item;
    logic            fr_valid;
    acc_pkg::carry_t fr_carry;
    logic [61:0]     fr_sum;

    logic            sq_valid [SN+1];
    acc_pkg::sqrt_t  sq_state [SN+1];
    acc_pkg::carry_t sq_carry [SN+1];

    logic            dv_valid [DN+1];
    acc_pkg::div_t   dv_state [DN+1];
    acc_pkg::carry_t dv_carry [DN+1];

    logic [199:0]    res_data_next;
    logic            res_hit_next;
    logic            in_fire, out_take;
    logic            out_valid_reg, skid_valid_reg;
    logic [199:0]    out_data_reg, skid_data_reg;
    logic            out_hit_reg, skid_hit_reg;

    assign in_item.box_center_x    = s_axis_tdata[31:0];
    assign in_item.box_center_y    = s_axis_tdata[63:32];
    assign in_item.box_half_width  = s_axis_tdata[94:64];
    assign in_item.box_half_height = s_axis_tdata[125:95];
    assign in_item.box_scale_x     = s_axis_tdata[156:126];
    assign in_item.box_scale_y     = s_axis_tdata[187:157];
    assign in_item.circle_center_x = s_axis_tdata[219:188];
    assign in_item.circle_center_y = s_axis_tdata[251:220];
    assign in_item.circle_radius   = s_axis_tdata[282:252];
    assign in_item.circle_scale    = s_axis_tdata[313:283];

    // The whole pipeline moves together while the skid stage is empty.
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    acc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (fr_valid),
        .out_carry (fr_carry),
        .out_sum   (fr_sum)
    );

    assign sq_valid[0]      = fr_valid;
    assign sq_state[0].n    = fr_sum;
    assign sq_state[0].rem  = '0;
    assign sq_state[0].root = '0;
    assign sq_carry[0]      = fr_carry;

    for (genvar i = 0; i < SN; i++) begin : g_sqrt
        acc_sqrt_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_sq     (sq_state[i]),
            .in_carry  (sq_carry[i]),
            .out_valid (sq_valid[i+1]),
            .out_sq    (sq_state[i+1]),
            .out_carry (sq_carry[i+1])
        );
    end

    acc_div_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid[SN]),
        .in_carry  (sq_carry[SN]),
        .in_dist   (sq_state[SN].root),
        .out_valid (dv_valid[0]),
        .out_div   (dv_state[0]),
        .out_carry (dv_carry[0])
    );

    for (genvar i = 0; i < DN; i++) begin : g_div
        acc_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[i]),
            .in_div    (dv_state[i]),
            .in_carry  (dv_carry[i]),
            .out_valid (dv_valid[i+1]),
            .out_div   (dv_state[i+1]),
            .out_carry (dv_carry[i+1])
        );
    end

    // Result assembly from the last divider stage.
    always_comb begin
        acc_pkg::carry_t    c;
        acc_pkg::div_t      d;
        logic signed [31:0] qs [acc_pkg::LANES];
        logic signed [31:0] px, py;
        logic [17:0]        nx, ny;
        logic [30:0]        depth;
        c = dv_carry[DN];
        d = dv_state[DN];
        for (int i = 0; i < acc_pkg::LANES; i++) begin
            qs[i] = d.lane[i].neg ? -$signed({1'b0, d.lane[i].q}) : $signed({1'b0, d.lane[i].q});
        end
        if (d.den < acc_pkg::TINY_DIST) begin
            // Near-zero distance: normal stays the raw vector, point is the centre.
            px = c.ccx;
            py = c.ccy;
            nx = c.vx[17:0];
            ny = c.vy[17:0];
        end else begin
            px = acc_pkg::sat32(36'(c.ccx) + 36'(qs[acc_pkg::LANE_PX]));
            py = acc_pkg::sat32(36'(c.ccy) + 36'(qs[acc_pkg::LANE_PY]));
            nx = qs[acc_pkg::LANE_NX][17:0];
            ny = qs[acc_pkg::LANE_NY][17:0];
        end
        depth = c.r - d.den;
        res_hit_next = c.hit;
        if (c.hit) begin
            res_data_next = {5'd0, depth, ny, nx, c.bpy, c.bpx, py, px};
        end else begin
            res_data_next = '0;
        end
    end

    assign in_fire  = dv_valid[DN] && en;
    assign out_take = out_valid_reg && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
                out_hit_reg  <= skid_hit_reg;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_data_reg <= res_data_next;
                out_hit_reg  <= res_hit_next;
            end else begin
                skid_data_reg <= res_data_next;
                skid_hit_reg  <= res_hit_next;
            end
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_hit_reg;

    `ACC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid stage full while output register empty")
    `ACC_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss transaction carries a nonzero payload")
    `ACC_ASSERT_NEXT(a_skid_catch, aclk, aresetn, in_fire && out_valid_reg && !m_axis_tready, skid_valid_reg, "result arriving at a stalled output was not held in the skid stage")

endmodule

// ===== test/acc_contact_checker.sv =====
`timescale 1ns / 1ps
// Checker for the box/circle contact block: watches both stream channels, predicts each result
// and compares it field by field. Depends on acc_pkg for the input item type.
module acc_contact_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [319:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [199:0] m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           errors,
    output int           contacts_due,
    output int           hits_seen,
    output int           results_seen
);

    typedef struct {
        logic               hit;
        logic signed [31:0] circle_point_x;
        logic signed [31:0] circle_point_y;
        logic signed [31:0] box_point_x;
        logic signed [31:0] box_point_y;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic [30:0]        depth;
    } contact_t;

    contact_t expected_contacts[$];

    function automatic acc_pkg::in_t unpack_pair(input logic [319:0] d);
        acc_pkg::in_t x;
        x.box_center_x    = d[31:0];
        x.box_center_y    = d[63:32];
        x.box_half_width  = d[94:64];
        x.box_half_height = d[125:95];
        x.box_scale_x     = d[156:126];
        x.box_scale_y     = d[187:157];
        x.circle_center_x = d[219:188];
        x.circle_center_y = d[251:220];
        x.circle_radius   = d[282:252];
        x.circle_scale    = d[313:283];
        return x;
    endfunction

    function automatic longint scaled_size(input logic [30:0] a, input logic [30:0] b);
        longint p;
        p = (longint'(a) * longint'(b) + 32768) >>> 16;
        return (p > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : p;
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_point(input longint x);
        return clip(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Round to nearest, halves away from zero; den is positive.
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q   = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic contact_t predict_contact(input acc_pkg::in_t a);
        contact_t c;
        longint bcx, bcy, ccx, ccy, hw, hh, r;
        longint dx, dy, cx, cy, vx, vy, distance, px, py, nx, ny;
        longint unsigned sum, rr;
        bcx = longint'(a.box_center_x);
        bcy = longint'(a.box_center_y);
        ccx = longint'(a.circle_center_x);
        ccy = longint'(a.circle_center_y);
        hw  = scaled_size(a.box_half_width, a.box_scale_x);
        hh  = scaled_size(a.box_half_height, a.box_scale_y);
        r   = scaled_size(a.circle_radius, a.circle_scale);
        dx  = ccx - bcx;
        dy  = ccy - bcy;
        cx  = clip(dx, -hw, hw);
        cy  = clip(dy, -hh, hh);
        vx  = cx - dx;
        vy  = cy - dy;
        c = '{hit: 1'b0, circle_point_x: '0, circle_point_y: '0, box_point_x: '0,
              box_point_y: '0, normal_x: '0, normal_y: '0, depth: '0};
        if (vx > r || -vx > r || vy > r || -vy > r) return c;
        sum = longint'(vx * vx) + longint'(vy * vy);
        rr  = r * r;
        if (sum > rr) return c;
        distance = longint'(floor_root(sum));
        if (distance >= 7) begin
            px = ccx + round_div(vx * r, distance);
            py = ccy + round_div(vy * r, distance);
            nx = round_div(vx * 65536, distance);
            ny = round_div(vy * 65536, distance);
        end else begin
            // Centers practically coincide with the box surface: no normalization.
            px = ccx;
            py = ccy;
            nx = vx;
            ny = vy;
        end
        c.hit            = 1'b1;
        c.circle_point_x = sat_point(px);
        c.circle_point_y = sat_point(py);
        c.box_point_x    = sat_point(bcx + cx);
        c.box_point_y    = sat_point(bcy + cy);
        c.normal_x       = nx[17:0];
        c.normal_y       = ny[17:0];
        c.depth          = 31'(r - distance);
        return c;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            errors++;
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    initial begin
        errors       = 0;
        contacts_due = 0;
        hits_seen    = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        contact_t e;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_contacts.push_back(predict_contact(unpack_pair(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser[0]) hits_seen++;
                if (expected_contacts.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with no item pending, actual tdata %h",
                             $time, m_axis_tdata);
                end else begin
                    e = expected_contacts.pop_front();
                    check_field("hit", e.hit, m_axis_tuser[0]);
                    check_field("circle_point_x", e.circle_point_x,
                                $signed(m_axis_tdata[31:0]));
                    check_field("circle_point_y", e.circle_point_y,
                                $signed(m_axis_tdata[63:32]));
                    check_field("box_point_x", e.box_point_x, $signed(m_axis_tdata[95:64]));
                    check_field("box_point_y", e.box_point_y, $signed(m_axis_tdata[127:96]));
                    check_field("normal_x", e.normal_x, $signed(m_axis_tdata[145:128]));
                    check_field("normal_y", e.normal_y, $signed(m_axis_tdata[163:146]));
                    check_field("depth", e.depth, m_axis_tdata[194:164]);
                end
            end
            contacts_due <= expected_contacts.size();
        end
    end

endmodule

// ===== test/tb_aabb_circle_contact.sv =====
`timescale 1ns / 1ps
// Testbench top for aabb_circle_contact: drives box/circle pairs with random idling and back
// pressure and gives the verdict. Depends on acc_pkg, acc_contact_checker and the block.
module tb_aabb_circle_contact;

    localparam int ONE        = 65536;
    localparam int IDLE_LIMIT = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int errors, contacts_due, hits_seen, results_seen;
    int send_idle_pct, stall_pct;
    logic out_hold, hold_request;
    int quiet_cycles;
    int pairs_sent;

    aabb_circle_contact u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    acc_contact_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .contacts_due(contacts_due),
        .hits_seen(hits_seen), .results_seen(results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic acc_pkg::in_t make_pair(input int bcx, input int bcy, input int hw,
                                               input int hh, input int sx, input int sy,
                                               input int ccx, input int ccy, input int r,
                                               input int cs);
        acc_pkg::in_t x;
        x.box_center_x    = bcx;
        x.box_center_y    = bcy;
        x.box_half_width  = hw[30:0];
        x.box_half_height = hh[30:0];
        x.box_scale_x     = sx[30:0];
        x.box_scale_y     = sy[30:0];
        x.circle_center_x = ccx;
        x.circle_center_y = ccy;
        x.circle_radius   = r[30:0];
        x.circle_scale    = cs[30:0];
        return x;
    endfunction

    function automatic logic [319:0] pack_pair(input acc_pkg::in_t x);
        return {6'd0, x.circle_scale, x.circle_radius, x.circle_center_y, x.circle_center_x,
                x.box_scale_y, x.box_scale_x, x.box_half_height, x.box_half_width,
                x.box_center_y, x.box_center_x};
    endfunction

    // Mostly shapes near each other so contacts are common; some grazing and some raw bits.
    function automatic acc_pkg::in_t random_pair();
        int kind, bx, by, hw, hh;
        kind = $urandom_range(99);
        bx   = $urandom;
        by   = $urandom;
        hw   = $urandom_range(1 << 20);
        hh   = $urandom_range(1 << 20);
        if (kind < 20) begin
            return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
        end else if (kind < 35) begin
            return make_pair(bx, by, hw, hh, ONE, ONE, bx + hw + $urandom_range(12),
                             by + $urandom_range(1 << 12), $urandom_range(64), ONE);
        end
        return make_pair(bx, by, hw, hh, $urandom_range(4 * ONE), $urandom_range(4 * ONE),
                         bx + $signed($urandom_range(1 << 22)) - (1 << 21),
                         by + $signed($urandom_range(1 << 22)) - (1 << 21),
                         $urandom_range(1 << 21), $urandom_range(ONE / 4, 3 * ONE));
    endfunction

    task automatic send_pair(input acc_pkg::in_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_pair(x);
        do @(posedge aclk); while (!s_axis_tready);
        pairs_sent++;
        @(negedge aclk);
    endtask

    // Receiver side ready, with random stalls and one long hold-off.
    always @(negedge aclk) begin
        m_axis_tready <= !out_hold && ($urandom_range(99) >= stall_pct);
    end

    initial begin
        out_hold = 1'b0;
        wait (hold_request);
        out_hold = 1'b1;
        repeat (300) @(negedge aclk);
        out_hold = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL aabb_circle_contact");
        $finish;
    end

    initial begin
        int max_s;
        max_s         = 32'h7FFF_FFFF;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        pairs_sent    = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed pairs.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(-1, -1, max_s, max_s, max_s, max_s, -1, -1, max_s, max_s));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, max_s, max_s, max_s, max_s,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, max_s, max_s));
        // Circle exactly touching the right face.
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 3 * ONE, 0, 2 * ONE, ONE));
        // Just one unit short of touching.
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 3 * ONE + 1, 0, 2 * ONE, ONE));
        // Far apart on one axis only.
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 0, 50 * ONE, ONE, ONE));
        // Circle center inside the box.
        send_pair(make_pair(ONE, ONE, 4 * ONE, 4 * ONE, ONE, ONE, ONE, 2 * ONE, ONE, ONE));
        // Distances just below and at the threshold of a usable normal.
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, ONE + 6, 0, ONE, ONE));
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, ONE + 7, 0, ONE, ONE));
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, -ONE - 3, ONE + 4, ONE, ONE));
        // Diagonal corner contacts in all four quadrants.
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, ONE));
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, -2 * ONE, 2 * ONE, 2 * ONE, ONE));
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, -2 * ONE, -2 * ONE, 2 * ONE, ONE));
        send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, -2 * ONE, 2 * ONE, ONE));
        // Circle point pushed past the top and the bottom of the coordinate range.
        send_pair(make_pair(32'h7FFF_FFFF, 0, 0, 0, ONE, ONE, 32'h7FF0_0000, 0, max_s, ONE));
        send_pair(make_pair(32'h8000_0000, 0, 0, 0, ONE, ONE, 32'h8010_0000, 0, max_s, ONE));
        // Scaled sizes that saturate, and scales of zero.
        send_pair(make_pair(0, 0, max_s, 1, max_s, ONE, 5 * ONE, 3, max_s, 2 * ONE));
        send_pair(make_pair(0, 0, 4 * ONE, 4 * ONE, 0, 0, ONE, ONE, 4 * ONE, 0));
        // Rounding of the half unit in the scaled sizes.
        send_pair(make_pair(0, 0, 1, 1, 32768, 32767, 3, 0, 3, 32768));

        // Random phases; the first one also stalls the output long enough to back up the pipe.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            for (int k = 0; k < 163; k++) send_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        wait (pairs_sent > 0 && contacts_due == 0 && !out_hold);
        repeat (80) @(posedge aclk);
        $display("Drove %0d box/circle pairs; %0d results checked, %0d of them contacts.",
                 pairs_sent, results_seen, hits_seen);
        if (errors == 0) begin
            $display("PASS aabb_circle_contact");
        end else begin
            $display("FAIL aabb_circle_contact");
        end
        $finish;
    end

endmodule
